### rtl/f2i_pkg.sv
// Shared types and codes for the float to integer converter.
package f2i_pkg;

  localparam logic [1:0] REG_ROUND_MODE = 2'd0;
  localparam logic [1:0] REG_OUT_FORMAT = 2'd1;
  localparam logic [1:0] REG_IN_DOUBLE  = 2'd2;

  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  localparam logic [1:0] KIND_FINITE = 2'd0;
  localparam logic [1:0] KIND_INF    = 2'd1;
  localparam logic [1:0] KIND_NAN    = 2'd2;

  // magnitudes are capped at 2^40, so 41 bits suffice
  localparam int MagW = 41;

  typedef struct packed {
    logic       round_mode;
    logic [2:0] out_format;
    logic       in_double;
  } cfg_t;

endpackage

### rtl/float_to_int_converter_top.sv
// Float to integer converter: decode, align/round, saturate, output register.
// One transaction enters per clock; each result passes through the decode,
// shift, round and saturate stages, then the output register, and is strobed
// by done for one cycle. The pipeline never stalls, since the receiver cannot
// hold results off; busy stays low. Configuration writes take effect on items
// accepted after the write.
module float_to_int_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits,
  input  logic        in_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output logic        done,
  output logic [31:0] result_bits,
  output logic        out_of_range,
  output logic        out_last
);

  f2i_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.round_mode <= 1'b0;
      cfg.out_format <= f2i_pkg::FMT_S32;
      cfg.in_double  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        f2i_pkg::REG_ROUND_MODE: cfg.round_mode <= cfg_data[0];
        f2i_pkg::REG_OUT_FORMAT: cfg.out_format <= cfg_data;
        f2i_pkg::REG_IN_DOUBLE:  cfg.in_double  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: decode ----------------
  logic        neg_c;
  logic [52:0] sig_c;
  logic [1:0]  kind_c;
  logic signed [12:0] ex_c;

  always_comb begin
    if (cfg.in_double) begin
      neg_c  = value_bits[63];
      sig_c  = {(value_bits[62:52] != 11'd0), value_bits[51:0]};
      if (value_bits[62:52] == 11'h7FF)
        kind_c = (value_bits[51:0] != 52'd0) ? f2i_pkg::KIND_NAN : f2i_pkg::KIND_INF;
      else
        kind_c = f2i_pkg::KIND_FINITE;
      ex_c = (value_bits[62:52] == 11'd0) ? -13'sd1074
           : $signed({2'b00, value_bits[62:52]}) - 13'sd1075;
    end else begin
      neg_c  = value_bits[31];
      sig_c  = {29'd0, (value_bits[30:23] != 8'd0), value_bits[22:0]};
      if (value_bits[30:23] == 8'hFF)
        kind_c = (value_bits[22:0] != 23'd0) ? f2i_pkg::KIND_NAN : f2i_pkg::KIND_INF;
      else
        kind_c = f2i_pkg::KIND_FINITE;
      ex_c = (value_bits[30:23] == 8'd0) ? -13'sd149
           : $signed({5'd0, value_bits[30:23]}) - 13'sd150;
    end
  end

  logic               v1, neg1, last1;
  logic [1:0]         kind1;
  logic [52:0]        sig1;
  logic signed [12:0] ex1;
  f2i_pkg::cfg_t      cfg1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    neg1  <= neg_c;
    kind1 <= kind_c;
    sig1  <= sig_c;
    ex1   <= ex_c;
    last1 <= in_last;
    cfg1  <= cfg;
  end

  // ---------------- stage 2: align ----------------
  // Left shift for ex >= 0 (cap when ex > 40 or bits lost past 2^40),
  // right shift for ex < 0 keeping the round bit and a sticky bit.
  logic        cap_c, half_c, frac_c;
  logic [63:0] ip_c;
  logic [5:0]  sh_c;
  logic [105:0] lsh_c;
  logic [63:0] rem_c;

  always_comb begin
    cap_c  = 1'b0;
    half_c = 1'b0;
    frac_c = 1'b0;
    ip_c   = 64'd0;
    lsh_c  = 106'd0;
    rem_c  = 64'd0;
    sh_c   = 6'd0;
    if (kind1 == f2i_pkg::KIND_INF) begin
      cap_c = 1'b1;
    end else if (ex1 >= 0) begin
      if (sig1 == 53'd0) ip_c = 64'd0;
      else if (ex1 > 13'sd40) cap_c = 1'b1;
      else begin
        sh_c  = ex1[5:0];
        lsh_c = {53'd0, sig1} << sh_c;
        if (lsh_c[105:41] != 65'd0) cap_c = 1'b1;
        else ip_c = {23'd0, lsh_c[40:0]};
      end
    end else if (ex1 < -13'sd63) begin
      frac_c = (sig1 != 53'd0);
    end else begin
      sh_c  = 6'((-ex1));
      ip_c  = {11'd0, sig1 >> sh_c};
      rem_c = {11'd0, sig1} & ((64'd1 << sh_c) - 64'd1);
      frac_c = (rem_c != 64'd0);
      half_c = rem_c[sh_c - 6'd1];
    end
  end

  logic        v2, neg2, last2, cap2, half2, frac2, nan2;
  logic [40:0] ip2;
  f2i_pkg::cfg_t cfg2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    neg2  <= neg1;
    last2 <= last1;
    nan2  <= (kind1 == f2i_pkg::KIND_NAN);
    cap2  <= cap_c | (ip_c[63:41] != 23'd0);
    ip2   <= ip_c[40:0];
    half2 <= half_c;
    frac2 <= frac_c;
    cfg2  <= cfg1;
  end

  // ---------------- stage 3: round ----------------
  logic [41:0] mag_sum_c;
  logic [40:0] mag_c;

  always_comb begin
    if (cfg2.round_mode)
      mag_sum_c = {1'b0, ip2} + {41'd0, half2};
    else
      mag_sum_c = {1'b0, ip2} + {41'd0, neg2 & frac2};
    if (cap2 || mag_sum_c > 42'h100_0000_0000)
      mag_c = 41'h100_0000_0000;
    else
      mag_c = mag_sum_c[40:0];
  end

  logic        v3, neg3, last3, nan3;
  logic [40:0] mag3;
  f2i_pkg::cfg_t cfg3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    neg3  <= neg2;
    last3 <= last2;
    nan3  <= nan2;
    mag3  <= mag_c;
    cfg3  <= cfg2;
  end

  // ---------------- stage 4: saturate ----------------
  logic signed [41:0] val_c, lo_c, hi_c;
  logic [31:0] res_c;
  logic        oor_c;

  always_comb begin
    case (cfg3.out_format)
      f2i_pkg::FMT_S8:  begin lo_c = -42'sd128;   hi_c = 42'sd127;   end
      f2i_pkg::FMT_U8:  begin lo_c = 42'sd0;      hi_c = 42'sd255;   end
      f2i_pkg::FMT_S16: begin lo_c = -42'sd32768; hi_c = 42'sd32767; end
      f2i_pkg::FMT_U16: begin lo_c = 42'sd0;      hi_c = 42'sd65535; end
      f2i_pkg::FMT_U32: begin lo_c = 42'sd0;      hi_c = 42'sd4294967295; end
      default:          begin lo_c = -42'sd2147483648; hi_c = 42'sd2147483647; end
    endcase
    val_c = neg3 ? -$signed({1'b0, mag3}) : $signed({1'b0, mag3});
    oor_c = 1'b0;
    if (val_c < lo_c) begin val_c = lo_c; oor_c = 1'b1; end
    if (val_c > hi_c) begin val_c = hi_c; oor_c = 1'b1; end
    res_c = val_c[31:0];
    if (nan3) begin
      res_c = 32'd0;
      oor_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v3;
    result_bits  <= res_c;
    out_of_range <= oor_c;
    out_last     <= last3;
  end

endmodule

### rtl/f2i_checker.sv
// Port-level checks for the float to integer converter.
module f2i_assert (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every transaction must be followed by a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 done) else $error("missing result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4)) else $error("unexpected result");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done) else $error("result after reset");

endmodule

bind float_to_int_converter_top f2i_assert u_f2i_assert (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
